>>> hw/rtl/lurt_pkg.sv
package lurt_pkg;

    // Widths fixed by the word format on the ports.
    localparam int SYMBOL_WIDTH = 8;
    localparam int RUN_BITS     = 16;
    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    // Defaults for the top-level parameters.
    localparam int SYMBOL_BITS_DEF   = 8;
    localparam int POSITION_BITS_DEF = 16;

    // Each table entry carries a string tag; tag zero means never written.
    localparam int EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

endpackage

>>> hw/rtl/lurt_table.sv
module lurt_table
    import lurt_pkg::*;
#(
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int DATA_BITS   = EPOCH_BITS + POSITION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [SYMBOL_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0]   o_rd_data,
    input  logic                   i_wr_en,
    input  logic [SYMBOL_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0]   i_wr_data,
    input  logic                   i_clear_start,
    output logic                   o_clearing
);

    localparam int DEPTH = 1 << SYMBOL_BITS;

    logic [DATA_BITS-1:0]   r_mem [DEPTH];
    logic [DATA_BITS-1:0]   r_rd_data;
    logic                   r_clearing;
    logic [SYMBOL_BITS-1:0] r_clr_addr;

    // The sweep writes a zero tag into every entry, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_clear_start) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SYMBOL_BITS'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

>>> hw/rtl/lurt_window.sv
module lurt_window
    import lurt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic [EPOCH_BITS-1:0]    i_prev_tag,
    input  logic [POSITION_BITS-1:0] i_prev_pos,
    input  logic [EPOCH_BITS-1:0]    i_epoch,
    input  logic [POSITION_BITS-1:0] i_start,
    input  logic [POSITION_BITS-1:0] i_pos,
    input  logic [POSITION_BITS-1:0] i_best,
    output logic [POSITION_BITS-1:0] o_start,
    output logic [POSITION_BITS-1:0] o_best
);

    logic                     repeat_hit;
    logic [POSITION_BITS-1:0] run_len;

    // A symbol repeats inside the window only if it was written during this
    // string and no earlier than the current window start.
    always_comb begin
        repeat_hit = (i_prev_tag == i_epoch) && (i_prev_pos >= i_start);
        o_start    = repeat_hit ? i_prev_pos + 1'b1 : i_start;
        run_len    = i_pos - o_start + 1'b1;
        o_best     = (run_len > i_best) ? run_len : i_best;
    end

endmodule

>>> hw/rtl/longest_unique_run_tracker_top.sv
// Longest repeat-free run tracker.
//
// The input channel carries one byte of a string per word, with
// i_final_symbol set on the last byte. For every string the block returns
// one word on the output channel: the length of the longest substring that
// holds no repeated symbol, and a flag that is set when the string ran past
// the position range or the length did not fit the 16-bit result.
//
// An accepted byte has its table entry read in the cycle it is taken and is
// resolved in the next cycle unless it is a final byte that must wait for
// the output register. One byte is taken every cycle unless a sweep runs
// or a final byte is held or wraps the tag: the table port does one read
// and one write per cycle; a repeat of the byte before takes the last write.
//
// Table entries carry a string tag, so no clearing is needed between
// strings. After reset, and again after every 255 strings when the tag
// wraps, a sweep clears all 2^SYMBOL_BITS table entries and o_ready stays
// low. If the receiver stalls, a finished result waits in the output
// register; bytes of the next string keep flowing until a final byte has to
// wait behind it.
module longest_unique_run_tracker_top
    import lurt_pkg::*;
#(
    parameter int SYMBOL_BITS   = SYMBOL_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SYMBOL_WIDTH-1:0] i_symbol,
    input  logic                    i_final_symbol,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [RUN_BITS-1:0]     o_longest_run,
    output logic                    o_overflowed
);

    localparam int DATA_BITS = EPOCH_BITS + POSITION_BITS;
    localparam int SEL_BITS  = (SYMBOL_BITS < SYMBOL_WIDTH) ? SYMBOL_BITS : SYMBOL_WIDTH;
    localparam int EXT_BITS  = (POSITION_BITS > RUN_BITS) ? POSITION_BITS : RUN_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic                     accept;
    logic [SYMBOL_BITS-1:0]   in_addr;
    logic                     clearing;
    logic [DATA_BITS-1:0]     rd_word;
    logic [DATA_BITS-1:0]     prev_word;

    // Resolve stage: the accepted byte whose table entry has been read.
    logic                     r_s1_valid;
    logic [SYMBOL_BITS-1:0]   r_s1_addr;
    logic                     r_s1_final;

    // The write done in the cycle the byte now resolving was read.
    logic                     r_fwd_valid;
    logic [SYMBOL_BITS-1:0]   r_fwd_addr;
    logic [DATA_BITS-1:0]     r_fwd_word;

    logic [EPOCH_BITS-1:0]    r_epoch;
    logic [POSITION_BITS-1:0] r_start;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_best;
    logic                     r_ovf;

    logic                     r_out_valid;
    logic [RUN_BITS-1:0]      r_out_run;
    logic                     r_out_ovf;

    logic                     s1_go;
    logic                     s1_in_range;
    logic                     wr_en;
    logic [DATA_BITS-1:0]     wr_word;
    logic                     clear_start;
    logic [POSITION_BITS-1:0] n_start;
    logic [POSITION_BITS-1:0] n_best;
    logic [EXT_BITS-1:0]      best_ext;
    logic [RUN_BITS-1:0]      n_run;
    logic                     n_ovf;

    assign in_addr = SYMBOL_BITS'(i_symbol[SEL_BITS-1:0]);

    // A final byte can only move on when the output register is free or is
    // being emptied in this cycle; other bytes never wait.
    assign s1_go = r_s1_valid && (!r_s1_final || !r_out_valid || i_ready);

    // When a final byte wraps the string tag, the table is swept before the
    // next byte is read, so no byte is taken alongside it.
    assign o_ready = !clearing &&
                     (!r_s1_valid ||
                      (s1_go && !(r_s1_final && (r_epoch == EPOCH_LAST))));
    assign accept  = i_valid && o_ready;

    assign s1_in_range = (r_pos != POS_MAX);
    assign wr_en       = s1_go && s1_in_range;
    assign wr_word     = {r_epoch, r_pos};
    assign clear_start = s1_go && r_s1_final && (r_epoch == EPOCH_LAST);

    assign prev_word = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_word : rd_word;

    lurt_table #(
        .SYMBOL_BITS (SYMBOL_BITS),
        .DATA_BITS   (DATA_BITS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (accept),
        .i_rd_addr     (in_addr),
        .o_rd_data     (rd_word),
        .i_wr_en       (wr_en),
        .i_wr_addr     (r_s1_addr),
        .i_wr_data     (wr_word),
        .i_clear_start (clear_start),
        .o_clearing    (clearing)
    );

    lurt_window #(
        .POSITION_BITS (POSITION_BITS)
    ) u_window (
        .i_prev_tag (prev_word[DATA_BITS-1:POSITION_BITS]),
        .i_prev_pos (prev_word[POSITION_BITS-1:0]),
        .i_epoch    (r_epoch),
        .i_start    (r_start),
        .i_pos      (r_pos),
        .i_best     (r_best),
        .o_start    (n_start),
        .o_best     (n_best)
    );

    // Result of a final byte, including that byte itself. Lengths that do
    // not fit the result port saturate and raise the overflow flag.
    always_comb begin
        best_ext = EXT_BITS'(s1_in_range ? n_best : r_best);
        if (best_ext > EXT_BITS'(RUN_MAX)) begin
            n_run = RUN_MAX;
            n_ovf = 1'b1;
        end else begin
            n_run = best_ext[RUN_BITS-1:0];
            n_ovf = r_ovf || !s1_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr   <= in_addr;
            r_s1_final  <= i_final_symbol;
            r_fwd_valid <= wr_en;
            r_fwd_addr  <= r_s1_addr;
            r_fwd_word  <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_FIRST;
            r_start <= '0;
            r_pos   <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_final) begin
                r_epoch <= (r_epoch == EPOCH_LAST) ? EPOCH_FIRST : r_epoch + 1'b1;
                r_start <= '0;
                r_pos   <= '0;
                r_best  <= '0;
                r_ovf   <= 1'b0;
            end else if (s1_in_range) begin
                r_start <= n_start;
                r_pos   <= r_pos + 1'b1;
                r_best  <= n_best;
            end else begin
                r_ovf   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_final) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_final) begin
            r_out_run <= n_run;
            r_out_ovf <= n_ovf;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_longest_run = r_out_run;
    assign o_overflowed  = r_out_ovf;

endmodule

>>> sim/longest_unique_run_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tracker, keeps its own copy of the
// per-string table and counters, and compares every result word with the
// oldest prediction.
module longest_unique_run_checker
    import lurt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [SYMBOL_WIDTH-1:0] i_symbol,
    input  logic                    i_final_symbol,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [RUN_BITS-1:0]     i_longest_run,
    input  logic                    i_overflowed,
    output int                      o_failures,
    output int                      o_waiting,
    output int                      o_bytes,
    output int                      o_strings,
    output int                      o_overflows,
    output int                      o_best_seen
);

    localparam int SYM_BITS  = SYMBOL_BITS_DEF;
    localparam int POS_BITS  = POSITION_BITS_DEF;
    localparam int SYM_COUNT = 1 << SYM_BITS;
    localparam logic [POS_BITS-1:0] POS_SAT = '1;

    typedef struct packed {
        logic [RUN_BITS-1:0] run;
        logic                ovf;
    } t_run_word;

    logic                seen_flag [SYM_COUNT];
    logic [POS_BITS-1:0] last_pos  [SYM_COUNT];
    logic [POS_BITS-1:0] win_start;
    logic [POS_BITS-1:0] cur_pos;
    logic [POS_BITS:0]   best_len;
    logic                ovf_seen;

    t_run_word expected_runs[$];

    task clear_string();
        for (int k = 0; k < SYM_COUNT; k++) begin
            seen_flag[k] = 1'b0;
            last_pos[k]  = '0;
        end
        win_start = '0;
        cur_pos   = '0;
        best_len  = '0;
        ovf_seen  = 1'b0;
    endtask

    task track_symbol(input logic [SYMBOL_WIDTH-1:0] sym_in, input logic last);
        logic [SYM_BITS-1:0] idx;
        logic [POS_BITS:0]   len;
        t_run_word           w;
        idx = sym_in[SYM_BITS-1:0];
        if (cur_pos == POS_SAT) begin
            // Saturated: the byte is not taken into the window.
            ovf_seen = 1'b1;
        end else begin
            if (seen_flag[idx] && last_pos[idx] >= win_start) begin
                win_start = last_pos[idx] + 1'b1;
            end
            last_pos[idx]  = cur_pos;
            seen_flag[idx] = 1'b1;
            len = {1'b0, cur_pos} - {1'b0, win_start} + 1'b1;
            if (len > best_len) begin
                best_len = len;
            end
            cur_pos = cur_pos + 1'b1;
        end
        if (last) begin
            w.ovf = ovf_seen;
            if (best_len > (POS_BITS+1)'(RUN_MAX)) begin
                w.run = RUN_MAX;
                w.ovf = 1'b1;
            end else begin
                w.run = RUN_BITS'(best_len);
            end
            expected_runs.push_back(w);
            clear_string();
        end
    endtask

    always @(posedge i_clk) begin
        t_run_word w;
        if (!i_rst_n) begin
            clear_string();
            expected_runs.delete();
            o_failures  <= 0;
            o_bytes     <= 0;
            o_strings   <= 0;
            o_overflows <= 0;
            o_best_seen <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected result word: longest_run %0d, overflowed %0d",
                           i_longest_run, i_overflowed);
                    o_failures <= o_failures + 1;
                end else begin
                    w = expected_runs.pop_front();
                    if (i_longest_run !== w.run || i_overflowed !== w.ovf) begin
                        o_failures <= o_failures + 1;
                    end
                    if (i_longest_run !== w.run) begin
                        $error("longest_run: expected %0d, actual %0d", w.run, i_longest_run);
                    end
                    if (i_overflowed !== w.ovf) begin
                        $error("overflowed: expected %0d, actual %0d", w.ovf, i_overflowed);
                    end
                    o_strings <= o_strings + 1;
                    if (w.ovf) begin
                        o_overflows <= o_overflows + 1;
                    end
                    if (int'(w.run) > o_best_seen) begin
                        o_best_seen <= int'(w.run);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                track_symbol(i_symbol, i_final_symbol);
                o_bytes <= o_bytes + 1;
            end
        end
        o_waiting <= expected_runs.size();
    end

endmodule

>>> sim/longest_unique_run_tracker_top_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the longest repeat-free run tracker. All
// prediction and comparison lives in the checker instantiated beside the
// block; this module only offers byte words, takes result words, and
// decides pass or fail at the end of the run.
module longest_unique_run_tracker_top_tb
    import lurt_pkg::*;
();

    // A long stretch of no handshake on either channel means the block hung.
    // The longest legal quiet stretch is the table sweep after reset or a
    // tag wrap, or the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_BYTES   = 160;
    localparam int WRAP_STRINGS   = 400;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [SYMBOL_WIDTH-1:0] i_symbol;
    logic                    i_final_symbol;
    logic                    o_valid;
    logic                    i_ready;
    logic [RUN_BITS-1:0]     o_longest_run;
    logic                    o_overflowed;

    int failures;
    int waiting;
    int bytes_seen;
    int strings_seen;
    int overflows_seen;
    int best_seen;

    // Idling on both sides is switched off for the last part of the run.
    bit idle_enable;
    // Set by the sender to ask the receiver for one long hold-off.
    bit hold_request;
    int holds_done;
    int idle_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longest_unique_run_tracker_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_symbol       (i_symbol),
        .i_final_symbol (i_final_symbol),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_longest_run  (o_longest_run),
        .o_overflowed   (o_overflowed)
    );

    longest_unique_run_checker run_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_symbol       (i_symbol),
        .i_final_symbol (i_final_symbol),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_longest_run  (o_longest_run),
        .i_overflowed   (o_overflowed),
        .o_failures     (failures),
        .o_waiting      (waiting),
        .o_bytes        (bytes_seen),
        .o_strings      (strings_seen),
        .o_overflows    (overflows_seen),
        .o_best_seen    (best_seen)
    );

    // Offer one byte word and return at the clock edge that accepts it.
    // Valid is only lowered at the start of an idle burst, so a word that
    // follows straight on never sees valid dropped and raised in one step.
    // o_ready is sampled at the falling edge, where it already holds the
    // value that the next rising edge will see.
    task automatic send_byte(input logic [SYMBOL_WIDTH-1:0] sym, input logic last);
        bit taken;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_symbol       <= sym;
        i_final_symbol <= last;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Send a text string, flagging its last character as the final byte.
    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++) begin
            send_byte(txt[k], k == txt.len() - 1);
        end
    endtask

    // Random string. The alphabet is either the full byte range or a narrow
    // band at a random base so that repeats are frequent, and some bytes
    // copy the byte one or two places back to hit the forwarding paths.
    task automatic send_random_string(input int len);
        int                      alpha;
        int                      r;
        logic [SYMBOL_WIDTH-1:0] base;
        logic [SYMBOL_WIDTH-1:0] sym;
        logic [SYMBOL_WIDTH-1:0] prev1;
        logic [SYMBOL_WIDTH-1:0] prev2;
        alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 24);
        base  = SYMBOL_WIDTH'($urandom);
        prev1 = '0;
        prev2 = '0;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 9);
            if (k >= 1 && r == 0) begin
                sym = prev1;
            end else if (k >= 2 && r == 1) begin
                sym = prev2;
            end else begin
                sym = base + SYMBOL_WIDTH'($urandom_range(0, alpha - 1));
            end
            send_byte(sym, k == len - 1);
            prev2 = prev1;
            prev1 = sym;
        end
    endtask

    // Mostly short strings, now and then a long one of 200 to 300 bytes.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return $urandom_range(1, 3);
        end else if (r < 88) begin
            return $urandom_range(4, 20);
        end else if (r < 97) begin
            return $urandom_range(21, 64);
        end
        return $urandom_range(200, 300);
    endfunction

    // A cyclic walk over the byte values, so that one window spans every
    // entry of the table.
    task automatic send_cyclic_string(input int len);
        logic [SYMBOL_WIDTH-1:0] sym;
        for (int k = 0; k < len; k++) begin
            sym = SYMBOL_WIDTH'(k);
            send_byte(sym, k == len - 1);
        end
    endtask

    // Receiver: takes result words with random stall bursts, and once holds
    // off for a long stretch so the result register fills and the block
    // stops taking bytes.
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on handshakes of either channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                         idle_cycles, waiting);
                $display("longest_unique_run_tracker_top verification failed");
                $finish;
            end
        end
    end

    // Main stimulus.
    initial begin
        int sent;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_symbol       = '0;
        i_final_symbol = 1'b0;
        idle_enable    = 1'b1;
        hold_request   = 1'b0;
        holds_done     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: a single byte, a back-to-back repeat, the
        // classic sliding case, a repeat whose earlier position already lies
        // before the window start, and the byte extremes.
        send_text("a");
        send_text("aa");
        send_text("abcabcbb");
        send_text("abba");
        send_text("dvdf");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // Random strings of mixed length and content.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            int len;
            len = pick_length();
            if (len > RANDOM_BYTES - sent) begin
                len = RANDOM_BYTES - sent;
            end
            send_random_string(len);
            sent += len;
        end

        // Many one- and two-byte strings, so the string tag wraps and the
        // table is swept in the middle of traffic. The long receiver
        // hold-off is requested partway through while bytes keep coming.
        for (int n = 0; n < WRAP_STRINGS; n++) begin
            if (n == 150) begin
                hold_request = 1'b1;
            end
            send_random_string($urandom_range(1, 2));
        end

        // Last part, with no idling on either side: one string that walks
        // every byte value once, then a short string with repeats.
        idle_enable = 1'b0;
        send_cyclic_string(256);
        send_text("abcabcbb");

        i_valid <= 1'b0;
        while (waiting != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d bytes in %0d strings (%0d saturated), longest run %0d.",
                 bytes_seen, strings_seen, overflows_seen, best_seen);
        $display("Receiver hold-offs of %0d cycles: %0d; failures: %0d.",
                 HOLD_CYCLES, holds_done, failures);
        if (failures == 0 && waiting == 0) begin
            $display("longest_unique_run_tracker_top verification clean");
        end else begin
            $display("longest_unique_run_tracker_top verification failed");
        end
        $finish;
    end

endmodule
